// ===== src/stepped_pulse_sequencer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer assertion macros
// Shared concurrent assertion forms for the sequencer's checker.
// ---------------------------------------------------------------------------
`ifndef STEPPED_PULSE_SEQUENCER_UNIT_ASSERT_SVH
`define STEPPED_PULSE_SEQUENCER_UNIT_ASSERT_SVH

// Implication checked in the same cycle.
`define SPU_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("stepped pulse sequencer check failed");

// Implication checked in the next cycle.
`define SPU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("stepped pulse sequencer check failed");

`endif

// ===== src/sps_pkg.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer package
// Widths, register indexes, phase codes and shared types.
// ---------------------------------------------------------------------------
package sps_pkg;

	localparam int unsigned NUM_STEPS  = 8;
	localparam int unsigned NUM_CYCLES = 1;

	localparam int unsigned TICK_W     = 24;
	localparam int unsigned LEVEL_W    = 16;
	localparam int unsigned DELTA_W    = 15;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned PHASE_W    = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned DROP_W     = COUNT_W + DELTA_W;
	localparam int unsigned DIFF_W     = DROP_W + 2;

	localparam logic [COUNT_W-1:0] STEP_LIMIT  = COUNT_W'(NUM_STEPS);
	localparam logic [COUNT_W-1:0] CYCLE_LIMIT = COUNT_W'(NUM_CYCLES);

	localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_PRE  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_STEP = 2'd2;
	localparam logic [PHASE_W-1:0] PHASE_REST = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEPOL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DELTA = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AMP    = 3'd7;

	localparam logic signed [DIFF_W-1:0]  DIFF_MIN  = -DIFF_W'(32768);
	localparam logic signed [DIFF_W-1:0]  DIFF_MAX  = DIFF_W'(32767);
	localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = 16'sh8000;
	localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 16'sh7FFF;

	typedef struct packed {
		logic        [TICK_W-1:0]  period_ticks;
		logic        [TICK_W-1:0]  delay_ticks;
		logic        [TICK_W-1:0]  window_end_ticks;
		logic        [TICK_W-1:0]  depol_ticks;
		logic signed [LEVEL_W-1:0] offset_level;
		logic signed [LEVEL_W-1:0] step_base;
		logic        [DELTA_W-1:0] step_delta;
		logic signed [LEVEL_W-1:0] max_amp_level;
	} cfg_t;

	typedef struct packed {
		logic [TICK_W-1:0]  elapsed_ticks;
		logic [TICK_W-1:0]  prepulse_ticks;
		logic [COUNT_W-1:0] step_index;
		logic [COUNT_W-1:0] cycle_count;
	} state_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] drive_level;
		logic        [PHASE_W-1:0] phase;
		logic        [COUNT_W-1:0] step_now;
	} result_t;

endpackage

// ===== src/sps_tick_if.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer tick channel
// One word per time tick, carrying the restart flag.
// ---------------------------------------------------------------------------
interface sps_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// ===== src/sps_result_if.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer result channel
// One word per tick: drive level, phase and current step.
// ---------------------------------------------------------------------------
interface sps_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sps_pkg::LEVEL_W-1:0]   drive_level;
	logic        [sps_pkg::PHASE_W-1:0]   phase;
	logic        [sps_pkg::COUNT_W-1:0]   step_now;

	modport source (output valid, output drive_level, output phase, output step_now,
		input ready);
	modport sink (input valid, input drive_level, input phase, input step_now,
		output ready);
endinterface

// ===== src/sps_cfg_if.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer configuration channel
// Register write words: register index and write data.
// ---------------------------------------------------------------------------
interface sps_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sps_pkg::CFG_IDX_W-1:0]      index;
	logic [sps_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/sps_step.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer tick step
// Works out one tick's result and the counter values that follow it.
// ---------------------------------------------------------------------------
module sps_step (
	input  sps_pkg::cfg_t    cfg,
	input  sps_pkg::state_t  state,
	input  logic             restart,
	output sps_pkg::state_t  state_nxt,
	output sps_pkg::result_t res
);
	import sps_pkg::*;

	state_t                    cur;
	logic        [DROP_W-1:0]  drop;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [LEVEL_W-1:0] step_level;
	logic                      in_window;

	assign cur       = restart ? '0 : state;
	assign drop      = DROP_W'(cur.step_index) * DROP_W'(cfg.step_delta);
	assign diff      = DIFF_W'(cfg.step_base) - signed'({2'b00, drop});
	assign in_window = (cur.elapsed_ticks >= cfg.delay_ticks)
		&& (cur.elapsed_ticks < cfg.window_end_ticks);

	always_comb begin
		if (diff < DIFF_MIN) begin
			step_level = LEVEL_MIN;
		end else if (diff > DIFF_MAX) begin
			step_level = LEVEL_MAX;
		end else begin
			step_level = diff[LEVEL_W-1:0];
		end
	end

	always_comb begin
		state_nxt       = cur;
		res.drive_level = cfg.offset_level;
		res.phase       = PHASE_IDLE;
		res.step_now    = cur.step_index;
		if (cur.cycle_count < CYCLE_LIMIT) begin
			if (cur.step_index < STEP_LIMIT) begin
				if (in_window) begin
					res.drive_level         = step_level;
					res.phase               = PHASE_STEP;
					state_nxt.elapsed_ticks = cur.elapsed_ticks + 24'd1;
				end else if (cur.prepulse_ticks < cfg.depol_ticks) begin
					res.drive_level          = cfg.max_amp_level;
					res.phase                = PHASE_PRE;
					state_nxt.prepulse_ticks = cur.prepulse_ticks + 24'd1;
				end else begin
					res.phase               = PHASE_REST;
					state_nxt.elapsed_ticks = cur.elapsed_ticks + 24'd1;
				end
				if (state_nxt.elapsed_ticks >= cfg.period_ticks) begin
					state_nxt.step_index     = cur.step_index + 8'd1;
					state_nxt.prepulse_ticks = '0;
					state_nxt.elapsed_ticks  = '0;
				end
			end
			if (state_nxt.step_index == STEP_LIMIT) begin
				state_nxt.cycle_count = cur.cycle_count + 8'd1;
				state_nxt.step_index  = '0;
			end
		end
		if (res.phase == PHASE_IDLE) begin
			res.step_now = state_nxt.step_index;
		end
	end
endmodule

// ===== src/stepped_pulse_sequencer_unit.sv =====
// An accepted tick word waits in the tick register until the result register is free or read.
// Throughput: one tick word per cycle unless the result channel stalls; the counter update
// for a tick is done in the single stage between the tick register and the result register.
// Reset: arst_n clears the counters, both pipeline valids and loads the
// configuration registers with their documented defaults.
// ---------------------------------------------------------------------------
// Stepped pulse sequencer unit
// Per-tick prepulse, stepped pulse and rest level sequencer.
// ---------------------------------------------------------------------------
module stepped_pulse_sequencer_unit (
	input  logic         clk,
	input  logic         arst_n,
	sps_tick_if.sink     tick,
	sps_result_if.source result,
	sps_cfg_if.sink      cfg
);
	import sps_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s1;
	logic    restart_s1;
	logic    valid_s2;
	logic    advance;

	assign advance   = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks     <= 24'd10000;
			cfg_q.delay_ticks      <= 24'd0;
			cfg_q.window_end_ticks <= 24'd1500;
			cfg_q.depol_ticks      <= 24'd10000;
			cfg_q.offset_level     <= 16'sd0;
			cfg_q.step_base        <= 16'sd0;
			cfg_q.step_delta       <= 15'd30;
			cfg_q.max_amp_level    <= 16'sd15;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PERIOD:     cfg_q.period_ticks     <= cfg.data[TICK_W-1:0];
				REG_DELAY:      cfg_q.delay_ticks      <= cfg.data[TICK_W-1:0];
				REG_WINDOW_END: cfg_q.window_end_ticks <= cfg.data[TICK_W-1:0];
				REG_DEPOL:      cfg_q.depol_ticks      <= cfg.data[TICK_W-1:0];
				REG_OFFSET:     cfg_q.offset_level     <= cfg.data[LEVEL_W-1:0];
				REG_STEP_BASE:  cfg_q.step_base        <= cfg.data[LEVEL_W-1:0];
				REG_STEP_DELTA: cfg_q.step_delta       <= cfg.data[DELTA_W-1:0];
				REG_MAX_AMP:    cfg_q.max_amp_level    <= cfg.data[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			restart_s1 <= tick.restart;
		end
	end

	sps_step u_step (
		.cfg       (cfg_q),
		.state     (state_q),
		.restart   (restart_s1),
		.state_nxt (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid       = valid_s2;
	assign result.drive_level = res_s2.drive_level;
	assign result.phase       = res_s2.phase;
	assign result.step_now    = res_s2.step_now;
endmodule

// ===== src/sps_checker.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer checker
// Port-level checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "stepped_pulse_sequencer_unit_assert.svh"

module sps_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           tick_valid,
	input logic                           tick_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [sps_pkg::PHASE_W-1:0]    phase,
	input logic [sps_pkg::COUNT_W-1:0]    step_now
);
	import sps_pkg::*;

	logic tick_fire;
	logic active_word;
	logic idle_word;

	assign tick_fire   = tick_valid && tick_ready;
	assign active_word = result_valid && (phase != PHASE_IDLE);
	assign idle_word   = result_valid && (phase == PHASE_IDLE);

	`SPU_ASSERT_NEXT(a_result_hold, clk, arst_n, (result_valid && !result_ready), result_valid)
	`SPU_ASSERT_IMPLY(a_active_step, clk, arst_n, active_word, (step_now < STEP_LIMIT))
	`SPU_ASSERT_IMPLY(a_idle_step, clk, arst_n, idle_word, (step_now == '0))
	`SPU_ASSERT_IMPLY(a_result_cause, clk, arst_n, $rose(result_valid), $past(tick_fire, 2))
endmodule

bind stepped_pulse_sequencer_unit sps_checker u_sps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.phase        (result.phase),
	.step_now     (result.step_now)
);

// ===== tb/sv/stepped_pulse_sequencer_unit_check.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer checker
// Follows the configuration, tick and result channels, keeps its own model
// of the sequencer counters and compares each result word with the level,
// phase and step index predicted for the tick word that caused it.
// ---------------------------------------------------------------------------
module stepped_pulse_sequencer_unit_check (
	input  logic       clk,
	input  logic       arst_n,
	sps_tick_if        tick,
	sps_result_if      result,
	sps_cfg_if         cfg,
	output int         fails,
	output int         outstanding,
	output int         checked,
	output logic [3:0] phases_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import sps_pkg::*;

	cfg_t    regs;
	state_t  seq;
	result_t got;
	result_t want;
	result_t levels_due [$];
	int      mismatches;
	int      results_seen;
	logic [3:0] seen;

	function automatic result_t sequence_tick(input logic restart_bit);
		result_t r;
		logic [COUNT_W-1:0] shown;
		int lvl;
		if (restart_bit) begin
			seq = '0;
		end
		shown = seq.step_index;
		r.drive_level = regs.offset_level;
		r.phase = PHASE_IDLE;
		if (seq.cycle_count < CYCLE_LIMIT) begin
			if (seq.step_index < STEP_LIMIT) begin
				if (seq.elapsed_ticks >= regs.delay_ticks &&
						seq.elapsed_ticks < regs.window_end_ticks) begin
					lvl = int'(regs.step_base) - int'(seq.step_index) * int'(regs.step_delta);
					if (lvl > int'(LEVEL_MAX)) begin
						r.drive_level = LEVEL_MAX;
					end else if (lvl < int'(LEVEL_MIN)) begin
						r.drive_level = LEVEL_MIN;
					end else begin
						r.drive_level = lvl[LEVEL_W-1:0];
					end
					r.phase = PHASE_STEP;
					seq.elapsed_ticks = seq.elapsed_ticks + 1'b1;
				end else if (seq.prepulse_ticks < regs.depol_ticks) begin
					r.drive_level = regs.max_amp_level;
					r.phase = PHASE_PRE;
					seq.prepulse_ticks = seq.prepulse_ticks + 1'b1;
				end else begin
					r.phase = PHASE_REST;
					seq.elapsed_ticks = seq.elapsed_ticks + 1'b1;
				end
				if (seq.elapsed_ticks >= regs.period_ticks) begin
					seq.step_index = seq.step_index + 1'b1;
					seq.prepulse_ticks = '0;
					seq.elapsed_ticks = '0;
				end
			end
			if (seq.step_index == STEP_LIMIT) begin
				seq.cycle_count = seq.cycle_count + 1'b1;
				seq.step_index = '0;
			end
		end
		if (r.phase == PHASE_IDLE) begin
			shown = seq.step_index;
		end
		r.step_now = shown;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.period_ticks = 10000;
			regs.delay_ticks = 0;
			regs.window_end_ticks = 1500;
			regs.depol_ticks = 10000;
			regs.offset_level = 0;
			regs.step_base = 0;
			regs.step_delta = 30;
			regs.max_amp_level = 15;
			seq = '0;
			levels_due.delete();
			mismatches = 0;
			results_seen = 0;
			seen = '0;
			fails <= 0;
			outstanding <= 0;
			checked <= 0;
			phases_seen <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PERIOD:     regs.period_ticks = cfg.data;
					REG_DELAY:      regs.delay_ticks = cfg.data;
					REG_WINDOW_END: regs.window_end_ticks = cfg.data;
					REG_DEPOL:      regs.depol_ticks = cfg.data;
					REG_OFFSET:     regs.offset_level = cfg.data[LEVEL_W-1:0];
					REG_STEP_BASE:  regs.step_base = cfg.data[LEVEL_W-1:0];
					REG_STEP_DELTA: regs.step_delta = cfg.data[DELTA_W-1:0];
					REG_MAX_AMP:    regs.max_amp_level = cfg.data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got.drive_level = result.drive_level;
				got.phase = result.phase;
				got.step_now = result.step_now;
				if (levels_due.size() == 0) begin
					if (mismatches < 10) begin
						$display("Unexpected result word at %0t: level %0d phase %0d step %0d",
							$time, got.drive_level, got.phase, got.step_now);
					end
					mismatches++;
				end else begin
					want = levels_due.pop_front();
					results_seen++;
					if (got.drive_level !== want.drive_level || got.phase !== want.phase ||
							got.step_now !== want.step_now) begin
						if (mismatches < 10) begin
							$display({"Mismatch at %0t: expected level %0d phase %0d step %0d,",
								" got level %0d phase %0d step %0d"}, $time,
								want.drive_level, want.phase, want.step_now,
								got.drive_level, got.phase, got.step_now);
						end
						mismatches++;
					end
				end
			end
			if (tick.valid && tick.ready) begin
				levels_due.push_back(sequence_tick(tick.restart));
				seen[levels_due[$].phase] = 1'b1;
			end
			fails <= mismatches;
			outstanding <= levels_due.size();
			checked <= results_seen;
			phases_seen <= seen;
		end
	end

endmodule

// ===== tb/sv/stepped_pulse_sequencer_unit_test.sv =====
// ---------------------------------------------------------------------------
// Stepped pulse sequencer testbench
// Drives tick words and register writes into the sequencer under changing
// flow control: a short directed set covering level extremes, saturation,
// zero period, empty window and a shortened period, then random settings
// with bursts of ticks. A separate checker predicts and compares results.
// ---------------------------------------------------------------------------
module stepped_pulse_sequencer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sps_pkg::*;

	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned ROUND_WORDS   = 150;

	logic clk;
	logic arst_n = 1'b0;
	int   fails;
	int   outstanding;
	int   checked;
	logic [3:0] phases_seen;
	int   tx_idle = 19;
	int   rx_idle = 61;
	int   words_sent = 0;
	int   settings_applied = 0;
	logic [CFG_DATA_W-1:0] image [8];

	sps_tick_if   tick ();
	sps_result_if result ();
	sps_cfg_if    cfg ();

	stepped_pulse_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.result (result),
		.cfg    (cfg)
	);

	stepped_pulse_sequencer_unit_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.result      (result),
		.cfg         (cfg),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked),
		.phases_seen (phases_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		result.ready <= ($urandom_range(0, 99) >= rx_idle);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((tick.valid && tick.ready) || (result.valid && result.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [CFG_DATA_W-1:0] pick_ticks(input int unsigned span);
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return CFG_DATA_W'($urandom);
			default: return CFG_DATA_W'($urandom_range(0, span));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return {8'($urandom), LEVEL_MIN};
			1: return {8'($urandom), LEVEL_MAX};
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic void draw_settings();
		image[REG_PERIOD] = pick_ticks(6);
		image[REG_DELAY] = pick_ticks(4);
		image[REG_WINDOW_END] = pick_ticks(8);
		image[REG_DEPOL] = pick_ticks(3);
		image[REG_OFFSET] = pick_level();
		image[REG_STEP_BASE] = pick_level();
		image[REG_STEP_DELTA] = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(0, 200)) :
			CFG_DATA_W'($urandom);
		image[REG_MAX_AMP] = pick_level();
	endfunction

	task automatic send_word(input logic restart_bit);
		while ($urandom_range(0, 99) < tx_idle) begin
			tick.valid <= 1'b0;
			@(posedge clk);
		end
		tick.valid <= 1'b1;
		tick.restart <= restart_bit;
		@(posedge clk);
		while (!tick.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic pause_until_drained();
		tick.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [7:0] mask);
		for (int i = 0; i < $size(image); i++) begin
			if (mask[i]) begin
				write_reg(CFG_IDX_W'(i), image[i]);
			end
		end
		cfg.valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic send_run(input int unsigned count, input logic restart_first);
		for (int n = 0; n < count; n++) begin
			if (n > 0 && $urandom_range(0, 79) == 0) begin
				pause_until_drained();
			end
			send_word(n == 0 ? restart_first : ($urandom_range(0, 49) == 0));
		end
	endtask

	initial begin
		int round_start;
		tick.valid = 1'b0;
		tick.restart = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_PERIOD;
		cfg.data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset settings both ticks fall in the stepped pulse window.
		send_word(1'b1);
		send_word(1'b0);
		pause_until_drained();

		// One-tick steps falling from the top level into saturation, then done.
		image[REG_PERIOD] = 24'd1;
		image[REG_DELAY] = 24'd0;
		image[REG_WINDOW_END] = 24'd1;
		image[REG_DEPOL] = 24'd0;
		image[REG_OFFSET] = {8'h00, LEVEL_MIN};
		image[REG_STEP_BASE] = {8'hFF, LEVEL_MAX};
		image[REG_STEP_DELTA] = 24'h007FFF;
		image[REG_MAX_AMP] = {8'h00, LEVEL_MAX};
		apply_settings(8'hFF);
		send_word(1'b1);
		repeat (9) send_word(1'b0);
		pause_until_drained();

		// A zero period with an empty window ends each period after one prepulse tick.
		image[REG_PERIOD] = 24'd0;
		image[REG_DELAY] = '1;
		image[REG_WINDOW_END] = 24'd0;
		image[REG_DEPOL] = 24'd2;
		image[REG_OFFSET] = {8'hFF, LEVEL_MAX};
		image[REG_STEP_BASE] = {8'h00, LEVEL_MIN};
		image[REG_STEP_DELTA] = 24'd0;
		image[REG_MAX_AMP] = {8'hFF, LEVEL_MIN};
		apply_settings(8'hFF);
		send_word(1'b1);
		repeat (8) send_word(1'b0);
		pause_until_drained();

		// The period is cut short below the elapsed count while the counters run on.
		image[REG_PERIOD] = '1;
		image[REG_DELAY] = 24'd0;
		image[REG_WINDOW_END] = '1;
		image[REG_DEPOL] = '1;
		apply_settings(8'h0F);
		send_word(1'b1);
		repeat (3) send_word(1'b0);
		pause_until_drained();
		image[REG_PERIOD] = 24'd2;
		apply_settings(8'h01 << REG_PERIOD);
		repeat (2) send_word(1'b0);
		pause_until_drained();

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					tx_idle = 19;
					rx_idle = 61;
				end
				1: begin
					tx_idle = 61;
					rx_idle = 19;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			round_start = words_sent;
			while (words_sent - round_start < ROUND_WORDS) begin
				pause_until_drained();
				draw_settings();
				apply_settings($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'hFF);
				send_run($urandom_range(15, 45), 1'($urandom_range(0, 1)));
			end
		end
		pause_until_drained();

		$display("Run covered %0d tick words under %0d register settings, %0d results checked.",
			words_sent, settings_applied, checked);
		$display("Phases reached (rest, step, prepulse, idle): %b", phases_seen);
		if (fails == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
